// File: sv/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared types, codes and keyword tables of the version string comparator.
// ----------------------------------------------------------------------------
package vsc_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int NUM_W       = 32;   // saturating component number
    localparam int COMP_W      = 34;   // signed component value
    localparam int KW_CNT      = 5;
    localparam int KW_MAX      = 5;
    localparam int K_W         = 3;

    typedef logic [1:0] t_cmd_code;
    localparam t_cmd_code CMD_APP_A = 2'd0;
    localparam t_cmd_code CMD_APP_B = 2'd1;
    localparam t_cmd_code CMD_CMP   = 2'd2;

    typedef logic signed [1:0] t_order;
    localparam t_order ORD_OLDER = 2'b11;
    localparam t_order ORD_EQUAL = 2'b00;
    localparam t_order ORD_NEWER = 2'b01;

    // keyword tables, tried in this order
    localparam logic [7:0] KW_TEXT [KW_CNT][KW_MAX] = '{
        '{"a", "l", "p", "h", "a"},
        '{"b", "e", "t", "a", 8'h00},
        '{"p", "r", "e", 8'h00, 8'h00},
        '{"r", "c", 8'h00, 8'h00, 8'h00},
        '{"p", "l", 8'h00, 8'h00, 8'h00}
    };
    localparam int KW_LEN [KW_CNT] = '{5, 4, 3, 2, 2};
    localparam int KW_VAL [KW_CNT] = '{-3, -2, -1, -1, 0};

    typedef enum logic [3:0] {
        OP_NOP, OP_APPEND, OP_INIT, OP_READ_POS, OP_CLASSIFY, OP_UNDER,
        OP_NUM, OP_KW, OP_KW_EVAL, OP_SAVE_A, OP_SET_ORDER, OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        CL_ZERO, CL_UNDER, CL_DOT, CL_DIGIT, CL_LETTER, CL_OTHER
    } t_cls;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_START, S_CLASSIFY, S_UNDER, S_NUM, S_KW,
        S_KW_EVAL, S_DONE, S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MODE_LOCK, MODE_REM_A, MODE_REM_B
    } t_mode;

    typedef struct packed {
        t_op    op;
        logic   sel;     // 0 first string, 1 second string
        logic   dest;    // digit run goes to revision when set
        t_order order;
    } t_dp_cmd;

    typedef struct packed {
        logic a_live;
        logic b_live;
        logic at_end;
        logic next_live;
        logic lp;
        t_cls cls;
        logic kw_more;
        logic ca_gt;
        logic ca_lt;
        logic comp_pos;
        logic comp_neg;
        logic rev_gt;
        logic rev_lt;
        logic out_full;
    } t_dp_status;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        if (c == 8'h00)                 return CL_ZERO;
        else if (c == "_")              return CL_UNDER;
        else if (c == ".")              return CL_DOT;
        else if (c >= "0" && c <= "9")  return CL_DIGIT;
        else if (l >= "a" && l <= "z")  return CL_LETTER;
        else                            return CL_OTHER;
    endfunction

endpackage

// File: sv/vsc_ctrl.sv
// ----------------------------------------------------------------------------
// vsc_ctrl
// Sequencer: takes words, walks both strings component by component and
// drives the datapath with one command per cycle.
// ----------------------------------------------------------------------------
module vsc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  vsc_pkg::t_cmd_code    i_cmd,
    output logic                  o_in_ready,
    input  vsc_pkg::t_dp_status   i_status,
    output vsc_pkg::t_dp_cmd      o_cmd
);

    vsc_pkg::t_state r_state, n_state;
    vsc_pkg::t_mode  r_mode, n_mode;
    logic            r_sel, n_sel;
    logic            r_dest, n_dest;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vsc_pkg::S_IDLE;
            r_mode  <= vsc_pkg::MODE_LOCK;
            r_sel   <= 1'b0;
            r_dest  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_sel   <= n_sel;
            r_dest  <= n_dest;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_sel       = r_sel;
        n_dest      = r_dest;
        o_in_ready  = 1'b0;
        o_cmd.op    = vsc_pkg::OP_NOP;
        o_cmd.sel   = r_sel;
        o_cmd.dest  = r_dest;
        o_cmd.order = vsc_pkg::ORD_EQUAL;
        unique case (r_state)
            vsc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == vsc_pkg::CMD_APP_A || i_cmd == vsc_pkg::CMD_APP_B) begin
                        o_cmd.op = vsc_pkg::OP_APPEND;
                    end else if (i_cmd == vsc_pkg::CMD_CMP) begin
                        o_cmd.op = vsc_pkg::OP_INIT;
                        n_state  = vsc_pkg::S_LOOP;
                    end
                end
            end
            vsc_pkg::S_LOOP: begin
                if (i_status.a_live && i_status.b_live) begin
                    n_mode  = vsc_pkg::MODE_LOCK;
                    n_sel   = 1'b0;
                    n_state = vsc_pkg::S_START;
                end else if (i_status.a_live) begin
                    n_mode  = vsc_pkg::MODE_REM_A;
                    n_sel   = 1'b0;
                    n_state = vsc_pkg::S_START;
                end else if (i_status.b_live) begin
                    n_mode  = vsc_pkg::MODE_REM_B;
                    n_sel   = 1'b1;
                    n_state = vsc_pkg::S_START;
                end else begin
                    // all components tie: revision decides
                    o_cmd.op    = vsc_pkg::OP_SET_ORDER;
                    o_cmd.order = i_status.rev_gt ? vsc_pkg::ORD_NEWER :
                                  i_status.rev_lt ? vsc_pkg::ORD_OLDER : vsc_pkg::ORD_EQUAL;
                    n_state     = vsc_pkg::S_FINISH;
                end
            end
            vsc_pkg::S_START: begin
                o_cmd.op = vsc_pkg::OP_READ_POS;
                n_state  = i_status.at_end ? vsc_pkg::S_DONE : vsc_pkg::S_CLASSIFY;
            end
            vsc_pkg::S_CLASSIFY: begin
                o_cmd.op = vsc_pkg::OP_CLASSIFY;
                n_state  = vsc_pkg::S_DONE;
                if (!i_status.lp) begin
                    unique case (i_status.cls)
                        vsc_pkg::CL_UNDER: begin
                            if (i_status.next_live) n_state = vsc_pkg::S_UNDER;
                        end
                        vsc_pkg::CL_DIGIT: begin
                            n_dest = 1'b0;
                            if (i_status.next_live) n_state = vsc_pkg::S_NUM;
                        end
                        vsc_pkg::CL_LETTER: begin
                            n_state = i_status.next_live ? vsc_pkg::S_KW : vsc_pkg::S_KW_EVAL;
                        end
                        default: n_state = vsc_pkg::S_DONE;
                    endcase
                end
            end
            vsc_pkg::S_UNDER: begin
                o_cmd.op = vsc_pkg::OP_UNDER;
                n_state  = vsc_pkg::S_DONE;
                if (i_status.cls == vsc_pkg::CL_DIGIT) begin
                    n_dest = 1'b1;
                    if (i_status.next_live) n_state = vsc_pkg::S_NUM;
                end
            end
            vsc_pkg::S_NUM: begin
                o_cmd.op = vsc_pkg::OP_NUM;
                if (!(i_status.cls == vsc_pkg::CL_DIGIT && i_status.next_live)) begin
                    n_state = vsc_pkg::S_DONE;
                end
            end
            vsc_pkg::S_KW: begin
                o_cmd.op = vsc_pkg::OP_KW;
                if (!i_status.kw_more) n_state = vsc_pkg::S_KW_EVAL;
            end
            vsc_pkg::S_KW_EVAL: begin
                o_cmd.op = vsc_pkg::OP_KW_EVAL;
                n_state  = vsc_pkg::S_DONE;
            end
            vsc_pkg::S_DONE: begin
                n_state = vsc_pkg::S_LOOP;
                unique case (r_mode)
                    vsc_pkg::MODE_LOCK: begin
                        if (!r_sel) begin
                            o_cmd.op = vsc_pkg::OP_SAVE_A;
                            n_sel    = 1'b1;
                            n_state  = vsc_pkg::S_START;
                        end else if (i_status.ca_gt || i_status.ca_lt) begin
                            o_cmd.op    = vsc_pkg::OP_SET_ORDER;
                            o_cmd.order = i_status.ca_gt ? vsc_pkg::ORD_NEWER
                                                         : vsc_pkg::ORD_OLDER;
                            n_state     = vsc_pkg::S_FINISH;
                        end
                    end
                    vsc_pkg::MODE_REM_A: begin
                        if (i_status.comp_pos || i_status.comp_neg) begin
                            o_cmd.op    = vsc_pkg::OP_SET_ORDER;
                            o_cmd.order = i_status.comp_pos ? vsc_pkg::ORD_NEWER
                                                            : vsc_pkg::ORD_OLDER;
                            n_state     = vsc_pkg::S_FINISH;
                        end
                    end
                    vsc_pkg::MODE_REM_B: begin
                        if (i_status.comp_pos || i_status.comp_neg) begin
                            o_cmd.op    = vsc_pkg::OP_SET_ORDER;
                            o_cmd.order = i_status.comp_pos ? vsc_pkg::ORD_OLDER
                                                            : vsc_pkg::ORD_NEWER;
                            n_state     = vsc_pkg::S_FINISH;
                        end
                    end
                    default: n_state = vsc_pkg::S_LOOP;
                endcase
            end
            vsc_pkg::S_FINISH: begin
                if (!i_status.out_full) begin
                    o_cmd.op = vsc_pkg::OP_FINISH;
                    n_state  = vsc_pkg::S_IDLE;
                end
            end
            default: n_state = vsc_pkg::S_IDLE;
        endcase
    end

    // the result register is never overwritten while a word waits in it
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == vsc_pkg::OP_FINISH) |-> !i_status.out_full)
        else $error("result loaded while output busy");
    // words are taken only while no compare is in flight; a taken compare starts the walk
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_cmd == vsc_pkg::CMD_CMP) |=> (r_state == vsc_pkg::S_LOOP))
        else $error("compare did not start the walk");
    // the second string is scanned in lockstep only after the first one
    a_lock_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vsc_pkg::S_DONE && r_mode == vsc_pkg::MODE_LOCK && !r_sel)
        |=> (r_sel && r_state == vsc_pkg::S_START))
        else $error("lockstep order broken");

endmodule

// File: sv/vsc_dp.sv
// ----------------------------------------------------------------------------
// vsc_dp
// Datapath: two text buffers, per-string scan registers, number and keyword
// accumulators, and the result register.
// ----------------------------------------------------------------------------
module vsc_dp #(
    parameter int MAX_LEN = vsc_pkg::MAX_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vsc_pkg::t_cmd_code    i_cmd,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_out_ready,
    input  vsc_pkg::t_dp_cmd      i_dcmd,
    output vsc_pkg::t_dp_status   o_status,
    output logic                  o_out_valid,
    output vsc_pkg::t_order       o_order,
    output logic                  o_truncated
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int SUM_W = POS_W + 1;

    logic [7:0]          mem_a [MAX_LEN];
    logic [7:0]          mem_b [MAX_LEN];
    logic [7:0]          r_rd_a, r_rd_b;

    logic [POS_W-1:0]    r_len_a, n_len_a, r_len_b, n_len_b;
    logic [POS_W-1:0]    r_pos [2], n_pos [2];
    logic [POS_W-1:0]    r_end [2], n_end [2];
    logic                r_lp [2], n_lp [2];
    logic [vsc_pkg::NUM_W-1:0] r_rev [2], n_rev [2];
    logic [vsc_pkg::NUM_W-1:0] r_acc, n_acc;
    logic signed [vsc_pkg::COMP_W-1:0] r_comp, n_comp, r_ca, n_ca;
    logic [vsc_pkg::K_W-1:0]    r_k, n_k;
    logic [vsc_pkg::KW_CNT-1:0] r_m, n_m;
    logic                r_ovf, n_ovf;
    vsc_pkg::t_order     r_res, n_res;
    logic                r_out_valid, n_out_valid;
    vsc_pkg::t_order     r_out_order, n_out_order;
    logic                r_out_trunc, n_out_trunc;

    logic                s;
    logic [7:0]          c, low;
    vsc_pkg::t_cls       cls;
    logic [3:0]          dig;
    logic [POS_W-1:0]    pos_s, end_s, avail;
    logic [SUM_W-1:0]    pos_p1, rd_off, rd_full;
    logic [IDX_W-1:0]    rd_idx;
    logic [vsc_pkg::NUM_W+3:0] acc10;
    logic [vsc_pkg::NUM_W-1:0] acc_next;
    logic                we_a, we_b;

    // current byte and scan position of the selected string
    assign s       = i_dcmd.sel;
    assign c       = s ? r_rd_b : r_rd_a;
    assign low     = vsc_pkg::to_lower(c);
    assign cls     = vsc_pkg::classify(c);
    assign dig     = c[3:0];
    assign pos_s   = r_pos[s];
    assign end_s   = r_end[s];
    assign avail   = end_s - pos_s;
    assign pos_p1  = {1'b0, pos_s} + SUM_W'(1);

    // read address: the byte at the scan position for OP_READ_POS, else a later byte of the scan
    always_comb begin
        unique case (i_dcmd.op)
            vsc_pkg::OP_READ_POS: rd_off = '0;
            vsc_pkg::OP_KW:       rd_off = SUM_W'(r_k) + SUM_W'(1);
            default:              rd_off = SUM_W'(1);
        endcase
    end
    assign rd_full = {1'b0, pos_s} + rd_off;
    assign rd_idx  = rd_full[IDX_W-1:0];

    // saturating decimal step
    assign acc10    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (vsc_pkg::NUM_W + 4)'(dig);
    assign acc_next = (acc10[vsc_pkg::NUM_W+3:vsc_pkg::NUM_W] != 4'd0)
                    ? {vsc_pkg::NUM_W{1'b1}} : acc10[vsc_pkg::NUM_W-1:0];

    assign we_a = (i_dcmd.op == vsc_pkg::OP_APPEND) && (i_cmd == vsc_pkg::CMD_APP_A)
               && (r_len_a < POS_W'(MAX_LEN));
    assign we_b = (i_dcmd.op == vsc_pkg::OP_APPEND) && (i_cmd == vsc_pkg::CMD_APP_B)
               && (r_len_b < POS_W'(MAX_LEN));

    // text buffers with registered read
    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[r_len_a[IDX_W-1:0]] <= i_text_byte;
        if (we_b) mem_b[r_len_b[IDX_W-1:0]] <= i_text_byte;
        r_rd_a <= mem_a[rd_idx];
        r_rd_b <= mem_b[rd_idx];
    end

    // datapath operations
    always_comb begin
        logic found;
        found       = 1'b0;
        n_len_a     = r_len_a;
        n_len_b     = r_len_b;
        n_pos       = r_pos;
        n_end       = r_end;
        n_lp        = r_lp;
        n_rev       = r_rev;
        n_acc       = r_acc;
        n_comp      = r_comp;
        n_ca        = r_ca;
        n_k         = r_k;
        n_m         = r_m;
        n_ovf       = r_ovf;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_order = r_out_order;
        n_out_trunc = r_out_trunc;
        unique case (i_dcmd.op)
            vsc_pkg::OP_APPEND: begin
                if (i_cmd == vsc_pkg::CMD_APP_A) begin
                    if (we_a) n_len_a = POS_W'(r_len_a + POS_W'(1));
                    else      n_ovf   = 1'b1;
                end else begin
                    if (we_b) n_len_b = POS_W'(r_len_b + POS_W'(1));
                    else      n_ovf   = 1'b1;
                end
            end
            vsc_pkg::OP_INIT: begin
                n_pos[0] = '0;
                n_pos[1] = '0;
                n_end[0] = r_len_a;
                n_end[1] = r_len_b;
                n_lp[0]  = 1'b0;
                n_lp[1]  = 1'b0;
                n_rev[0] = '0;
                n_rev[1] = '0;
            end
            vsc_pkg::OP_READ_POS: begin
                n_comp = '0;
            end
            vsc_pkg::OP_CLASSIFY: begin
                n_comp = '0;
                if (r_lp[s]) begin
                    // pending letter gives its alphabet index
                    n_lp[s]  = 1'b0;
                    n_pos[s] = POS_W'(pos_p1);
                    n_comp   = $signed({{(vsc_pkg::COMP_W-8){1'b0}}, 8'(low - 8'h60)});
                end else begin
                    unique case (cls)
                        vsc_pkg::CL_ZERO: n_end[s] = pos_s;
                        vsc_pkg::CL_DIGIT: begin
                            n_acc    = vsc_pkg::NUM_W'(dig);
                            n_comp   = vsc_pkg::COMP_W'(dig);
                            n_pos[s] = POS_W'(pos_p1);
                        end
                        vsc_pkg::CL_LETTER: begin
                            n_k = vsc_pkg::K_W'(1);
                            for (int j = 0; j < vsc_pkg::KW_CNT; j++) begin
                                n_m[j] = (low == vsc_pkg::KW_TEXT[j][0]);
                            end
                        end
                        default: n_pos[s] = POS_W'(pos_p1);
                    endcase
                end
            end
            vsc_pkg::OP_UNDER: begin
                n_comp = '0;
                if (cls == vsc_pkg::CL_DIGIT) begin
                    n_acc    = vsc_pkg::NUM_W'(dig);
                    n_rev[s] = vsc_pkg::NUM_W'(dig);
                    n_pos[s] = POS_W'(pos_p1);
                end
            end
            vsc_pkg::OP_NUM: begin
                if (cls == vsc_pkg::CL_DIGIT) begin
                    n_acc    = acc_next;
                    n_pos[s] = POS_W'(pos_p1);
                    if (i_dcmd.dest) n_rev[s] = acc_next;
                    else             n_comp   = $signed({2'b00, acc_next});
                end
            end
            vsc_pkg::OP_KW: begin
                for (int j = 0; j < vsc_pkg::KW_CNT; j++) begin
                    if ((int'(r_k) < vsc_pkg::KW_LEN[j]) && (low != vsc_pkg::KW_TEXT[j][r_k])) begin
                        n_m[j] = 1'b0;
                    end
                end
                n_k = vsc_pkg::K_W'(r_k + vsc_pkg::K_W'(1));
            end
            vsc_pkg::OP_KW_EVAL: begin
                // first keyword that matches wholly inside the string wins
                n_comp = '0;
                for (int j = 0; j < vsc_pkg::KW_CNT; j++) begin
                    if (!found && r_m[j] && (avail >= POS_W'(vsc_pkg::KW_LEN[j]))) begin
                        found    = 1'b1;
                        n_pos[s] = POS_W'(pos_s + POS_W'(vsc_pkg::KW_LEN[j]));
                        n_comp   = vsc_pkg::COMP_W'(vsc_pkg::KW_VAL[j]);
                    end
                end
                if (!found) n_lp[s] = 1'b1;
            end
            vsc_pkg::OP_SAVE_A:    n_ca  = r_comp;
            vsc_pkg::OP_SET_ORDER: n_res = i_dcmd.order;
            vsc_pkg::OP_FINISH: begin
                n_out_valid = 1'b1;
                n_out_order = r_res;
                n_out_trunc = r_ovf;
                n_len_a     = '0;
                n_len_b     = '0;
                n_ovf       = 1'b0;
            end
            default: n_comp = r_comp;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_end[0]    <= '0;
            r_end[1]    <= '0;
            r_k         <= '0;
        end else begin
            r_len_a     <= n_len_a;
            r_len_b     <= n_len_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_end       <= n_end;
            r_k         <= n_k;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lp        <= n_lp;
        r_rev       <= n_rev;
        r_acc       <= n_acc;
        r_comp      <= n_comp;
        r_ca        <= n_ca;
        r_m         <= n_m;
        r_res       <= n_res;
        r_out_order <= n_out_order;
        r_out_trunc <= n_out_trunc;
    end

    // status toward the sequencer
    always_comb begin
        o_status.a_live    = r_pos[0] < r_end[0];
        o_status.b_live    = r_pos[1] < r_end[1];
        o_status.at_end    = pos_s >= end_s;
        o_status.next_live = pos_p1 < {1'b0, end_s};
        o_status.lp        = r_lp[s];
        o_status.cls       = cls;
        o_status.kw_more   = (r_k < vsc_pkg::K_W'(vsc_pkg::KW_MAX - 1))
                          && (({1'b0, pos_s} + SUM_W'(r_k) + SUM_W'(1)) < {1'b0, end_s});
        o_status.ca_gt     = r_ca > r_comp;
        o_status.ca_lt     = r_ca < r_comp;
        o_status.comp_pos  = r_comp > 0;
        o_status.comp_neg  = r_comp < 0;
        o_status.rev_gt    = r_rev[0] > r_rev[1];
        o_status.rev_lt    = r_rev[0] < r_rev[1];
        o_status.out_full  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_order     = r_out_order;
    assign o_truncated = r_out_trunc;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= POS_W'(MAX_LEN)) && (r_len_b <= POS_W'(MAX_LEN)))
        else $error("buffer length beyond capacity");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos[0] <= r_end[0]) && (r_pos[1] <= r_end[1]))
        else $error("scan position past string end");
    a_kw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dcmd.op == vsc_pkg::OP_KW) |-> (r_k < vsc_pkg::K_W'(vsc_pkg::KW_MAX)))
        else $error("keyword index out of range");

endmodule

// File: sv/version_string_compare.sv
// ----------------------------------------------------------------------------
// version_string_compare
// Loads two version strings byte by byte and orders them component-wise.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+-------------------------
//   in      | i_in_valid | o_in_ready  | i_cmd, i_text_byte
//   out     | o_out_valid| i_out_ready | o_order, o_truncated
//
// An append word is taken while the sequencer is idle. A compare walks both
// buffers through one registered read per cycle; a letter that is no keyword
// is tried as a keyword probe first, then gives its alphabet index.
// Reset is synchronous, active low, and empties both buffers.
// Appends are still taken while a result waits; a compare holds at its end
// until the result register is free.
// ----------------------------------------------------------------------------
module version_string_compare #(
    parameter int MAX_LEN = vsc_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [1:0] o_order,
    output logic        o_truncated
);

    vsc_pkg::t_dp_cmd    dcmd;
    vsc_pkg::t_dp_status status;

    // sequencer
    vsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (dcmd)
    );

    // buffers and scan datapath
    vsc_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_text_byte (i_text_byte),
        .i_out_ready (i_out_ready),
        .i_dcmd      (dcmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_order     (o_order),
        .o_truncated (o_truncated)
    );

endmodule
